// ===== hdl/tun_pkg.sv =====
// shared constants and width helpers for the triangle unit normal block
// no dependencies

package tun_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 14;

	// width of the sum of squares of the cross product
	function automatic int s_bits(input int c);
		return 4 * c + 4;
	endfunction

	// width of the squared-quotient trial values in the rounding cells
	function automatic int t_bits(input int c, input int f);
		return s_bits(c) + 2 * f + 5;
	endfunction

endpackage

// ===== hdl/triangle_unit_normal.sv =====
// Unit normal of a triangle: takes one triangle per cycle when not stalled and
// gives its normal (B-A) x (C-A) scaled to length 2^FRAC_BITS, each component
// rounded to nearest, ties away from zero, as signed Q1.FRAC_BITS; a zero cross
// product gives zeros with degenerate set. Throughput is one word per cycle while
// the output is not stalled. The pipeline is five front stages, one rounding cell
// per result bit (FRAC_BITS+1 cells), then the output register. Stalls collapse
// bubbles, so input is taken while a finished word waits at the output.

module triangle_unit_normal import tun_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] ax,
	input  logic [COORD_BITS-1:0] ay,
	input  logic [COORD_BITS-1:0] az,
	input  logic [COORD_BITS-1:0] bx,
	input  logic [COORD_BITS-1:0] by_coord,
	input  logic [COORD_BITS-1:0] bz,
	input  logic [COORD_BITS-1:0] cx,
	input  logic [COORD_BITS-1:0] cy,
	input  logic [COORD_BITS-1:0] cz,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FRAC_BITS+1:0]  nx,
	output logic [FRAC_BITS+1:0]  ny,
	output logic [FRAC_BITS+1:0]  nz,
	output logic                  degenerate
);

	localparam int SB = s_bits(COORD_BITS);
	localparam int TW = t_bits(COORD_BITS, FRAC_BITS);
	localparam int NC = FRAC_BITS + 1;
	localparam int NS = 5 + NC;
	localparam int OW = FRAC_BITS + 2;

	logic [NS:0]   rdy;
	logic [NS-1:0] v_q;
	logic          out_valid_q;

	logic [SB-1:0]        cs   [NC+1];
	logic [2:0]           cn   [NC+1];
	logic [TW-1:0]        crhs [NC+1][3];
	logic [FRAC_BITS:0]   cr   [NC+1][3];
	logic [TW-1:0]        cp   [NC+1][3];
	logic signed [TW-1:0] cq   [NC+1][3];

	logic [OW-1:0] comp [3];
	logic [OW-1:0] nx_q, ny_q, nz_q;
	logic          deg_q;

	// a stage moves when it is empty or the one after it moves
	always_comb begin
		rdy[NS] = !out_valid_q || !out_stall;
		for (int i = NS - 1; i >= 0; i--)
			rdy[i] = !v_q[i] || rdy[i+1];
	end

	assign in_stall = !rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy[0])
				v_q[0] <= in_valid;
			for (int i = 1; i < NS; i++)
				if (rdy[i])
					v_q[i] <= v_q[i-1];
			if (rdy[NS])
				out_valid_q <= v_q[NS-1];
		end
	end

	tun_front #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk     (clk),
		.en      (rdy[4:0]),
		.ax      (ax),
		.ay      (ay),
		.az      (az),
		.bx      (bx),
		.by_coord(by_coord),
		.bz      (bz),
		.cx      (cx),
		.cy      (cy),
		.cz      (cz),
		.s       (cs[0]),
		.neg     (cn[0]),
		.rhs     (crhs[0])
	);

	// chain starts with r = 0, so 2r-1 = -1
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cr[0][j] = '0;
			cp[0][j] = TW'(cs[0]);
			cq[0][j] = -$signed(TW'(cs[0]));
		end
	end

	for (genvar k = 0; k < NC; k++) begin : g_cell
		tun_cell #(
			.SB (SB),
			.TW (TW),
			.F  (FRAC_BITS),
			.BIT(FRAC_BITS - k)
		) u_cell (
			.clk     (clk),
			.en      (rdy[5+k]),
			.prev_s  (cs[k]),
			.prev_neg(cn[k]),
			.prev_rhs(crhs[k]),
			.prev_r  (cr[k]),
			.prev_p  (cp[k]),
			.prev_q  (cq[k]),
			.s       (cs[k+1]),
			.neg     (cn[k+1]),
			.rhs     (crhs[k+1]),
			.r       (cr[k+1]),
			.p       (cp[k+1]),
			.q       (cq[k+1])
		);
	end

	always_comb begin
		for (int j = 0; j < 3; j++)
			comp[j] = cn[NC][j] ? -OW'(cr[NC][j]) : OW'(cr[NC][j]);
	end

	always_ff @(posedge clk) begin
		if (rdy[NS]) begin
			if (cs[NC] == '0) begin
				nx_q  <= '0;
				ny_q  <= '0;
				nz_q  <= '0;
				deg_q <= 1'b1;
			end else begin
				nx_q  <= comp[0];
				ny_q  <= comp[1];
				nz_q  <= comp[2];
				deg_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign nx         = nx_q;
	assign ny         = ny_q;
	assign nz         = nz_q;
	assign degenerate = deg_q;

	localparam int LIM = 1 << FRAC_BITS;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> nx == '0 && ny == '0 && nz == '0)
		else $error("degenerate word with nonzero component");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register empty");

	a_mag_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $signed(nx) <= LIM && $signed(nx) >= -LIM)
		else $error("normal x component beyond unit range");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && (&v_q))
		else $error("input stalled with a free stage");

endmodule

// ===== hdl/tun_front.sv =====
// front end: edges, cross product, squares and sum of squares over five stages
// depends on tun_pkg

module tun_front import tun_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic [4:0]                             en,
	input  logic [COORD_BITS-1:0]                  ax,
	input  logic [COORD_BITS-1:0]                  ay,
	input  logic [COORD_BITS-1:0]                  az,
	input  logic [COORD_BITS-1:0]                  bx,
	input  logic [COORD_BITS-1:0]                  by_coord,
	input  logic [COORD_BITS-1:0]                  bz,
	input  logic [COORD_BITS-1:0]                  cx,
	input  logic [COORD_BITS-1:0]                  cy,
	input  logic [COORD_BITS-1:0]                  cz,
	output logic [s_bits(COORD_BITS)-1:0]          s,
	output logic [2:0]                             neg,
	output logic [t_bits(COORD_BITS, FRAC_BITS)-1:0] rhs [3]
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;
	localparam int MB = 2 * COORD_BITS + 1;
	localparam int QW = 2 * MB;
	localparam int SB = s_bits(COORD_BITS);
	localparam int TW = t_bits(COORD_BITS, FRAC_BITS);

	logic signed [DW-1:0] u_s1 [3];
	logic signed [DW-1:0] v_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic signed [PW-1:0] n    [3];
	logic [MB-1:0]        m_s3 [3];
	logic [2:0]           neg_s3;
	logic [QW-1:0]        q_s4 [3];
	logic [2:0]           neg_s4;
	logic [SB-1:0]        s_s5;
	logic [2:0]           neg_s5;
	logic [TW-1:0]        rhs_s5 [3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			u_s1[0] <= $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});
			u_s1[1] <= $signed({by_coord[COORD_BITS-1], by_coord})
				- $signed({ay[COORD_BITS-1], ay});
			u_s1[2] <= $signed({bz[COORD_BITS-1], bz}) - $signed({az[COORD_BITS-1], az});
			v_s1[0] <= $signed({cx[COORD_BITS-1], cx}) - $signed({ax[COORD_BITS-1], ax});
			v_s1[1] <= $signed({cy[COORD_BITS-1], cy}) - $signed({ay[COORD_BITS-1], ay});
			v_s1[2] <= $signed({cz[COORD_BITS-1], cz}) - $signed({az[COORD_BITS-1], az});
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s2[0] <= u_s1[1] * v_s1[2];
			p_s2[1] <= u_s1[2] * v_s1[1];
			p_s2[2] <= u_s1[2] * v_s1[0];
			p_s2[3] <= u_s1[0] * v_s1[2];
			p_s2[4] <= u_s1[0] * v_s1[1];
			p_s2[5] <= u_s1[1] * v_s1[0];
		end
	end

	always_comb begin
		n[0] = p_s2[0] - p_s2[1];
		n[1] = p_s2[2] - p_s2[3];
		n[2] = p_s2[4] - p_s2[5];
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < 3; j++) begin
				neg_s3[j] <= n[j][PW-1];
				m_s3[j]   <= n[j][PW-1] ? MB'(-n[j]) : MB'(n[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int j = 0; j < 3; j++)
				q_s4[j] <= m_s3[j] * m_s3[j];
			neg_s4 <= neg_s3;
		end
	end

	// rhs is the squared component scaled by 2^(2F+2)
	always_ff @(posedge clk) begin
		if (en[4]) begin
			s_s5 <= SB'(q_s4[0]) + SB'(q_s4[1]) + SB'(q_s4[2]);
			for (int j = 0; j < 3; j++)
				rhs_s5[j] <= TW'(q_s4[j]) << (2 * FRAC_BITS + 2);
			neg_s5 <= neg_s4;
		end
	end

	assign s   = s_s5;
	assign neg = neg_s5;
	assign rhs = rhs_s5;

endmodule

// ===== hdl/tun_cell.sv =====
// one rounding cell: settles one bit of each normal component magnitude
// no package dependencies; widths come from the top level

module tun_cell #(
	parameter int SB  = 52,
	parameter int TW  = 85,
	parameter int F   = 14,
	parameter int BIT = 14
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [SB-1:0]        prev_s,
	input  logic [2:0]           prev_neg,
	input  logic [TW-1:0]        prev_rhs [3],
	input  logic [F:0]           prev_r   [3],
	input  logic [TW-1:0]        prev_p   [3],
	input  logic signed [TW-1:0] prev_q   [3],
	output logic [SB-1:0]        s,
	output logic [2:0]           neg,
	output logic [TW-1:0]        rhs [3],
	output logic [F:0]           r   [3],
	output logic [TW-1:0]        p   [3],
	output logic signed [TW-1:0] q   [3]
);

	localparam bit CAP = (BIT < F);

	logic [TW-1:0]        sx;
	logic [TW-1:0]        trial [3];
	logic                 take  [3];
	logic [SB-1:0]        s_s1;
	logic [2:0]           neg_s1;
	logic [TW-1:0]        rhs_s1 [3];
	logic [F:0]           r_s1   [3];
	logic [TW-1:0]        p_s1   [3];
	logic signed [TW-1:0] q_s1   [3];

	// p = (2r-1)^2 s, q = (2r-1) s; trial is (2r+2^(b+1)-1)^2 s
	always_comb begin
		sx = TW'(prev_s);
		for (int j = 0; j < 3; j++) begin
			trial[j] = prev_p[j] + $unsigned(prev_q[j] <<< (BIT + 2)) + (sx << (2 * BIT + 2));
			take[j]  = !(CAP && prev_r[j][F]) && (trial[j] <= prev_rhs[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= prev_s;
			neg_s1 <= prev_neg;
			for (int j = 0; j < 3; j++) begin
				rhs_s1[j] <= prev_rhs[j];
				if (take[j]) begin
					r_s1[j] <= prev_r[j] | ((F+1)'(1) << BIT);
					p_s1[j] <= trial[j];
					q_s1[j] <= prev_q[j] + $signed(sx << (BIT + 1));
				end else begin
					r_s1[j] <= prev_r[j];
					p_s1[j] <= prev_p[j];
					q_s1[j] <= prev_q[j];
				end
			end
		end
	end

	assign s   = s_s1;
	assign neg = neg_s1;
	assign rhs = rhs_s1;
	assign r   = r_s1;
	assign p   = p_s1;
	assign q   = q_s1;

endmodule

// ===== tb/tun_checker.sv =====
// checker for the triangle unit normal block: watches both channels, predicts
// each normal with exact integer arithmetic and compares field by field
// depends on nothing but the port widths
`timescale 1ns / 1ps

module tun_checker #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [COORD_BITS-1:0] ax, ay, az, bx, by_coord, bz, cx, cy, cz,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [FRAC_BITS+1:0]  nx, ny, nz,
	input  logic                  degenerate,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [FRAC_BITS+1:0] nx, ny, nz;
		logic                 degenerate;
	} normal_t;

	normal_t expected_normals[$];

	// largest r in 0..2^F with (2r-1)^2 * s <= m^2 * 2^(2F+2)
	function automatic logic [FRAC_BITS+1:0] unit_component(longint n, longint s);
		logic [127:0] lhs, rhs;
		longint mag, r, t, odd;
		mag = (n < 0) ? -n : n;
		rhs = 128'(mag * mag) << (2 * FRAC_BITS + 2);
		r = 0;
		for (int b = FRAC_BITS; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t <= (longint'(1) << FRAC_BITS)) begin
				odd = 2 * t - 1;
				lhs = 128'(odd * odd) * 128'(s);
				if (lhs <= rhs)
					r = t;
			end
		end
		if (n < 0)
			r = -r;
		return r[FRAC_BITS+1:0];
	endfunction

	function automatic normal_t predict_normal(
		logic signed [COORD_BITS-1:0] pax, pay, paz, pbx, pby, pbz, pcx, pcy, pcz);
		normal_t p;
		longint ux, uy, uz, vx, vy, vz, n0, n1, n2, s;
		ux = longint'(pbx) - pax; uy = longint'(pby) - pay; uz = longint'(pbz) - paz;
		vx = longint'(pcx) - pax; vy = longint'(pcy) - pay; vz = longint'(pcz) - paz;
		n0 = uy * vz - uz * vy;
		n1 = uz * vx - ux * vz;
		n2 = ux * vy - uy * vx;
		s = n0 * n0 + n1 * n1 + n2 * n2;
		if (s == 0) begin
			p = '0;
			p.degenerate = 1'b1;
		end else begin
			p.nx = unit_component(n0, s);
			p.ny = unit_component(n1, s);
			p.nz = unit_component(n2, s);
			p.degenerate = 1'b0;
		end
		return p;
	endfunction

	assign pending = expected_normals.size();

	always @(posedge clk) begin
		normal_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_normals.push_back(predict_normal(ax, ay, az, bx, by_coord, bz,
					cx, cy, cz));
			if (out_valid && !out_stall) begin
				if (expected_normals.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					e = expected_normals.pop_front();
					if (nx !== e.nx) begin
						$error("nx expected %0d got %0d", $signed(e.nx), $signed(nx));
						fail_count++;
					end
					if (ny !== e.ny) begin
						$error("ny expected %0d got %0d", $signed(e.ny), $signed(ny));
						fail_count++;
					end
					if (nz !== e.nz) begin
						$error("nz expected %0d got %0d", $signed(e.nz), $signed(nz));
						fail_count++;
					end
					if (degenerate !== e.degenerate) begin
						$error("degenerate expected %0b got %0b", e.degenerate, degenerate);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// top of the triangle unit normal testbench: clock, reset, vertex stimulus,
// receiver stalls and verdict; depends on tun_pkg, the block and tun_checker
`timescale 1ns / 1ps

module tb_top;
	import tun_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic [CB-1:0] ax = '0, ay = '0, az = '0, bx = '0, by_coord = '0, bz = '0;
	logic [CB-1:0] cx = '0, cy = '0, cz = '0;
	logic in_stall, out_valid, degenerate;
	logic [FB+1:0] nx, ny, nz;
	int fail_count, pending;
	int send_idle_pct = 24, recv_idle_pct = 53;
	int quiet_cycles = 0;
	bit timed_out = 1'b0;

	always #4 clk = ~clk;

	triangle_unit_normal dut (.*);

	tun_checker #(.COORD_BITS(CB), .FRAC_BITS(FB)) checker_i (.*);

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [CB-1:0] rand_coord();
		case ($urandom_range(5))
			0: return {1'b1, {(CB-1){1'b0}}};
			1: return {1'b0, {(CB-1){1'b1}}};
			2: return CB'($urandom_range(7)) - CB'(4);
			default: return CB'($urandom);
		endcase
	endfunction

	// offers one triangle word, with an optional random gap first
	task automatic send_triangle(input logic [CB-1:0] v[9]);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{ax, ay, az, bx, by_coord, bz, cx, cy, cz} <= {v[0], v[1], v[2], v[3], v[4],
			v[5], v[6], v[7], v[8]};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int count);
		logic [CB-1:0] v[9];
		for (int i = 0; i < count; i++) begin
			foreach (v[k]) v[k] = rand_coord();
			// collinear and coincident vertices for degenerate words
			if ($urandom_range(9) == 0) begin
				v[6] = v[0] + ((v[3] - v[0]) << 1);
				v[7] = v[1] + ((v[4] - v[1]) << 1);
				v[8] = v[2] + ((v[5] - v[2]) << 1);
			end else if ($urandom_range(19) == 0) begin
				v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
			end
			send_triangle(v);
		end
	endtask

	localparam logic [CB-1:0] MX = {1'b0, {(CB-1){1'b1}}};
	localparam logic [CB-1:0] MN = {1'b1, {(CB-1){1'b0}}};

	initial begin
		logic [CB-1:0] d[9];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// axis-aligned, extreme and degenerate triangles
		d = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                   send_triangle(d);
		d = '{0, 0, 0, 0, 1, 0, 1, 0, 0};                   send_triangle(d);
		d = '{MN, MN, MN, MX, MN, MN, MN, MX, MN};          send_triangle(d);
		d = '{MX, MX, MX, MN, MX, MX, MX, MN, MX};          send_triangle(d);
		d = '{MN, MN, MN, MX, MX, MX, MN, MX, MX};          send_triangle(d);
		d = '{MX, MN, MX, MN, MX, MN, MX, MX, MN};          send_triangle(d);
		d = '{5, 5, 5, 5, 5, 5, 5, 5, 5};                   send_triangle(d);
		d = '{MN, MN, MN, MX, MX, MX, MN, MN, MN};          send_triangle(d);
		d = '{0, 0, 0, 1, 1, 1, 2, 2, 2};                   send_triangle(d);
		d = '{0, 0, 0, 1, 2, 0, 0, 0, 1};                   send_triangle(d);
		d = '{0, 0, 0, 1, 0, 0, 1, 1, 0};                   send_triangle(d);
		d = '{0, 0, 0, 3, 0, 0, 0, 4, 5};                   send_triangle(d);
		d = '{MX, 0, 0, 0, MX, 0, 0, 0, MX};                send_triangle(d);
		d = '{MN, 0, 0, 0, MN, 0, 0, 0, MN};                send_triangle(d);
		d = '{0, 0, 0, 1, 1, 0, MX, MN, 1};                 send_triangle(d);
		drain();
		random_phase(200);
		drain();
		send_idle_pct = 53;
		recv_idle_pct = 24;
		random_phase(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(200);
		drain();
		repeat (3 * (FB + 7)) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
